FILE: design/qta_pkg.sv
// shared types, constants and helpers of the quadtree tile allocator
package qta_pkg;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  localparam int MaxLevelCap = 8;

  // first heap index of each level, (4^l - 1) / 3
  localparam logic [14:0] LEVEL_START [0:MaxLevelCap] = '{
    15'd0, 15'd1, 15'd5, 15'd21, 15'd85, 15'd341, 15'd1365, 15'd5461, 15'd21845
  };

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_A_RD, ST_A_CHK, ST_A_UPCHK, ST_A_TAKE, ST_INC, ST_T_CHK, ST_DONE
  } state_t;

  typedef struct packed {
    logic [16:0] atlas;
    logic [4:0]  alog;
    logic [3:0]  levels;
  } cfg_info_t;

  function automatic logic [4:0] log2_of(input logic [16:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic logic is_pow2(input logic [16:0] v);
    return (v != '0) && ((v & (v - 17'd1)) == '0);
  endfunction

endpackage

FILE: design/quadtree_tile_allocator_unit.sv
// top level of the quadtree tile allocator
// Quadtree buddy allocator for square power-of-two tiles. Each heap node keeps an
// allocated bit and a 15-bit count of allocated descendants in one single-port-write,
// registered-read node ram; a small sequencer walks that ram, so every word is
// handled one at a time and in_stall stays high until it is done. Allocate tries
// the nodes of the requested level in turn, checking each candidate and walking its
// ancestors, then marks the winner and raises the count of every ancestor; free of
// an allocated tile clears its bit and lowers every ancestor's count. After reset,
// after a clear word and after any register write, a clearing pass over all
// (4^MAX_LEVELS-1)/3 nodes (21845 at the default) zeroes the ram before the next
// word is taken; a clear word reports ok once that pass ends. Registers sit at
// byte addresses 0 (atlas_size) and 4 (min_tile_size); a result waits in the
// output register while the next word is already being worked on.
module quadtree_tile_allocator_unit import qta_pkg::*; #(
  parameter int MAX_LEVELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [16:0] tile_size,
  input  logic [14:0] target_node,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [14:0] node_index,
  output logic        allocated,
  output logic [15:0] region_x,
  output logic [15:0] region_y,
  output logic [16:0] region_size,
  output logic [14:0] live_count
);

  localparam logic [14:0] Depth = LEVEL_START[MAX_LEVELS];
  localparam int AW = (Depth > 15'd1) ? $clog2(int'(Depth)) : 1;

  // configuration registers and derived geometry
  logic [16:0] atlas_size;
  logic [16:0] min_tile_size;
  logic        cfg_wr;
  logic [4:0]  alog;
  logic [4:0]  mlog;
  logic [4:0]  span;
  logic [3:0]  levels;
  cfg_info_t   info;
  logic [14:0] total;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? 32'(min_tile_size) : 32'(atlas_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_size    <= '0;
      min_tile_size <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) min_tile_size <= pwdata[16:0];
      else          atlas_size    <= pwdata[16:0];
    end
  end

  always_comb begin
    alog   = log2_of(atlas_size);
    mlog   = log2_of(min_tile_size);
    span   = alog - mlog;
    levels = '0;
    if (is_pow2(atlas_size) && is_pow2(min_tile_size) && min_tile_size <= atlas_size
        && span < 5'(MAX_LEVELS)) begin
      levels = 4'(span) + 4'd1;
    end
    info  = '{atlas: atlas_size, alog: alog, levels: levels};
    total = LEVEL_START[levels];
  end

  // node ram: bit 15 allocated, bits 14:0 descendant count
  logic [15:0]   node_ram [0:int'(Depth)-1];
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          we;
  logic [15:0]   rdata;

  always_ff @(posedge clk) begin
    if (we) node_ram[waddr] <= wdata;
    rdata <= node_ram[raddr];
  end

  // sequencer state
  state_t      state, state_next;
  logic [14:0] cur, cur_next;          // candidate, target, then reported node
  logic [14:0] walk, walk_next;        // ancestor pointer
  logic [14:0] end_n, end_n_next;      // first node past the level
  logic [1:0]  mode_r, mode_r_next;
  logic        res_ok, res_ok_next;
  logic        res_alloc, res_alloc_next;
  logic        res_reg, res_reg_next;  // region fields are reported
  logic        clr_reply, clr_reply_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [14:0] tiles_live, tiles_live_next;
  logic        load_out;

  logic        accept;
  logic [4:0]  slog;
  logic [2:0]  req_level;
  logic        req_ok;
  logic [14:0] par_cur;
  logic [14:0] par_walk;
  logic [14:0] cnt;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign par_cur  = (cur - 15'd1) >> 2;
  assign par_walk = (walk - 15'd1) >> 2;
  assign cnt      = rdata[14:0];

  always_comb begin
    slog      = log2_of(tile_size);
    req_level = 3'(alog - slog);
    req_ok    = (levels != '0) && is_pow2(tile_size) && tile_size >= min_tile_size
                && tile_size <= atlas_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      tiles_live <= '0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      clr_reply  <= clr_reply_next;
      tiles_live <= tiles_live_next;
    end
    cur       <= cur_next;
    walk      <= walk_next;
    end_n     <= end_n_next;
    mode_r    <= mode_r_next;
    res_ok    <= res_ok_next;
    res_alloc <= res_alloc_next;
    res_reg   <= res_reg_next;
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    walk_next       = walk;
    end_n_next      = end_n;
    mode_r_next     = mode_r;
    res_ok_next     = res_ok;
    res_alloc_next  = res_alloc;
    res_reg_next    = res_reg;
    clr_reply_next  = clr_reply;
    clr_addr_next   = clr_addr;
    tiles_live_next = tiles_live;
    raddr           = cur[AW-1:0];
    waddr           = clr_addr;
    wdata           = '0;
    we              = 1'b0;
    load_out        = 1'b0;

    case (state)
      ST_CLR: begin
        we            = 1'b1;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(Depth - 15'd1)) begin
          clr_addr_next = '0;
          state_next    = clr_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mode_r_next = mode;
          case (mode)
            MODE_ALLOC: begin
              if (req_ok) begin
                cur_next   = LEVEL_START[req_level];
                end_n_next = LEVEL_START[4'(req_level) + 4'd1];
                state_next = ST_A_RD;
              end else begin
                cur_next       = '0;
                res_ok_next    = 1'b0;
                res_alloc_next = 1'b0;
                res_reg_next   = 1'b0;
                state_next     = ST_DONE;
              end
            end
            MODE_CLEAR: begin
              cur_next        = '0;
              res_ok_next     = 1'b1;
              res_alloc_next  = 1'b0;
              res_reg_next    = 1'b0;
              clr_reply_next  = 1'b1;
              clr_addr_next   = '0;
              tiles_live_next = '0;
              state_next      = ST_CLR;
            end
            default: begin
              cur_next = target_node;
              raddr    = target_node[AW-1:0];
              if (target_node < total) begin
                state_next = ST_T_CHK;
              end else begin
                res_ok_next    = 1'b0;
                res_alloc_next = 1'b0;
                res_reg_next   = 1'b0;
                state_next     = ST_DONE;
              end
            end
          endcase
        end
      end
      ST_A_RD: begin
        raddr      = cur[AW-1:0];
        state_next = ST_A_CHK;
      end
      ST_A_CHK, ST_A_UPCHK: begin
        if ((state == ST_A_CHK && (rdata[15] || cnt != '0)) ||
            (state == ST_A_UPCHK && rdata[15])) begin
          // candidate blocked, try the next one in the level
          if (cur + 15'd1 == end_n) begin
            cur_next       = '0;
            res_ok_next    = 1'b0;
            res_alloc_next = 1'b0;
            res_reg_next   = 1'b0;
            state_next     = ST_DONE;
          end else begin
            cur_next   = cur + 15'd1;
            state_next = ST_A_RD;
          end
        end else if ((state == ST_A_CHK && cur == '0) ||
                     (state == ST_A_UPCHK && walk == '0)) begin
          state_next = ST_A_TAKE;
        end else if (state == ST_A_CHK) begin
          walk_next  = par_cur;
          raddr      = par_cur[AW-1:0];
          state_next = ST_A_UPCHK;
        end else begin
          walk_next = par_walk;
          raddr     = par_walk[AW-1:0];
        end
      end
      ST_A_TAKE: begin
        we              = 1'b1;
        waddr           = cur[AW-1:0];
        wdata           = 16'h8000;
        tiles_live_next = tiles_live + 15'd1;
        res_ok_next     = 1'b1;
        res_alloc_next  = 1'b1;
        res_reg_next    = 1'b1;
        if (cur == '0) begin
          state_next = ST_DONE;
        end else begin
          walk_next  = par_cur;
          raddr      = par_cur[AW-1:0];
          state_next = ST_INC;
        end
      end
      ST_INC: begin
        // update the descendant count of one ancestor, read the next
        we    = 1'b1;
        waddr = walk[AW-1:0];
        if (mode_r == MODE_ALLOC) wdata = {rdata[15], cnt + 15'd1};
        else                      wdata = {rdata[15], (cnt != '0) ? cnt - 15'd1 : cnt};
        if (walk == '0) begin
          state_next = ST_DONE;
        end else begin
          walk_next = par_walk;
          raddr     = par_walk[AW-1:0];
        end
      end
      ST_T_CHK: begin
        res_reg_next   = 1'b1;
        res_alloc_next = rdata[15];
        res_ok_next    = (mode_r == MODE_QUERY);
        state_next     = ST_DONE;
        if (mode_r == MODE_FREE && rdata[15]) begin
          we              = 1'b1;
          waddr           = cur[AW-1:0];
          wdata           = {1'b0, cnt};
          tiles_live_next = tiles_live - 15'd1;
          res_ok_next     = 1'b1;
          res_alloc_next  = 1'b0;
          if (cur != '0) begin
            walk_next  = par_cur;
            raddr      = par_cur[AW-1:0];
            state_next = ST_INC;
          end
        end else if (mode_r == MODE_FREE) begin
          res_alloc_next = 1'b0;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out       = 1'b1;
          clr_reply_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_CLR;
    endcase

    // a register write empties the table
    if (cfg_wr) begin
      state_next      = ST_CLR;
      clr_addr_next   = '0;
      clr_reply_next  = 1'b0;
      tiles_live_next = '0;
    end
  end

  // region of the reported node
  logic [15:0] rx;
  logic [15:0] ry;
  logic [16:0] rs;

  qta_region #(.MAX_LEVELS(MAX_LEVELS)) u_region (
    .node        (cur),
    .info        (info),
    .region_x    (rx),
    .region_y    (ry),
    .region_size (rs)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      ok          <= res_ok;
      node_index  <= cur;
      allocated   <= res_alloc;
      region_x    <= res_reg ? rx : '0;
      region_y    <= res_reg ? ry : '0;
      region_size <= res_reg ? rs : '0;
      live_count  <= tiles_live;
    end
  end

  // checks
  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_CLEAR && !cfg_wr) |=> (state == ST_CLR))
    else $error("clear word did not start a sweep");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the done step");

  a_walk_up: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INC) |-> (walk < cur))
    else $error("ancestor walk not above its node");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLR) |-> in_stall)
    else $error("word taken during clearing pass");

endmodule

FILE: design/qta_region.sv
// square position and side of one heap node
module qta_region import qta_pkg::*; #(
  parameter int MAX_LEVELS = 8
) (
  input  logic [14:0] node,
  input  cfg_info_t   info,
  output logic [15:0] region_x,
  output logic [15:0] region_y,
  output logic [16:0] region_size
);

  logic [2:0]  level;
  logic [14:0] local_idx;
  logic [7:0]  ix;
  logic [7:0]  iy;
  logic [4:0]  sh;

  always_comb begin
    level = '0;
    for (int l = 1; l < MAX_LEVELS; l++) begin
      if (4'(l) < info.levels && node >= LEVEL_START[l]) level = 3'(l);
    end
    local_idx = node - LEVEL_START[level];
    ix = '0;
    iy = '0;
    for (int k = 0; k < 7; k++) begin
      if (3'(k) < level) begin
        ix[k] = local_idx[2*k];
        iy[k] = local_idx[2*k+1];
      end
    end
    sh          = info.alog - 5'(level);
    region_x    = 16'(32'(ix) << sh);
    region_y    = 16'(32'(iy) << sh);
    region_size = info.atlas >> level;
  end

endmodule
